>>> rtl/core/dett_pkg.sv
// ----------------------------------------------------------------------------
// dett_pkg
// Shared types, codes and constants of the delayed event timer table.
// ----------------------------------------------------------------------------
package dett_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [31:0] ELAPSED_MASK = 32'h00FF_FFFF;
  localparam logic [31:0] INT_MAX_MARK = 32'h7FFF_FFFF;
  localparam logic [31:0] MS_MULT      = 32'd1000;
  localparam int          MS_SHIFT     = 10;
  localparam logic [7:0]  ESC_BYTE     = 8'hFF;
  localparam logic [31:0] MIN_DELAY    = 32'd2;

  // operation codes
  localparam logic [1:0] OP_STEP   = 2'd0;
  localparam logic [1:0] OP_SCHED  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_PUSH  = 3'd1;
  localparam logic [2:0] ST_SCHED = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] event_id;
    logic [31:0] event_context;
    logic [31:0] delay_ms;
    logic [31:0] tick_now;
    logic [31:0] callback_word;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] due_event;
    logic [31:0] due_context;
    logic [2:0]  status;
    logic [4:0]  slot_used;
    logic [4:0]  cleared_count;
    logic [31:0] elapsed_ms;
    logic [31:0] soonest_delay;
    logic        timer_start;
    logic        empty_reload;
    logic        int_max_suppressed;
    logic        last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       decode;
    logic       idx_clr;
    logic       idx_inc;
    logic       find_take;
    logic       cancel_scan;
    logic       step_scan;
    logic       use_elapsed;
    logic       min_clr;
    logic       sum_set;
    logic       sum_step;
    logic [2:0] sum_code;
    logic       sum_full;
    logic       emit_due;
    logic       emit_sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       ev_zero;
    logic       delay_small;
    logic       slot_valid;
    logic       removed_zero;
    logic       due_hit;
    logic       idx_last;
  } sts_t;

endpackage

>>> rtl/core/dett_dp.sv
// ----------------------------------------------------------------------------
// dett_dp
// Datapath: slot store, scan index, saturating subtract, running minimum,
// armed timer registers and result item formation.
// ----------------------------------------------------------------------------
module dett_dp (
  input  logic          clk,
  input  logic          rst,
  input  dett_pkg::in_t  in_item,
  input  dett_pkg::cmd_t cmd,
  output dett_pkg::sts_t sts,
  output dett_pkg::out_t res
);
  import dett_pkg::*;

  in_t              in_r;
  logic [31:0]      now_ms;
  logic [31:0]      elapsed;
  logic [31:0]      applied;
  logic [31:0]      shown;
  logic [2:0]       sum_status;
  logic [CNT_W-1:0] sum_slot;
  logic             sum_step;
  logic [CNT_W-1:0] removed;
  logic [31:0]      next_min;
  logic             active;
  logic             p_live;
  logic [31:0]      p_rem;
  logic [31:0]      armed_delay;
  logic [31:0]      armed_start;
  logic [IDX_W-1:0] idx;
  logic [SLOTS-1:0] valid;
  logic [31:0]      ev_mem  [SLOTS];
  logic [31:0]      ctx_mem [SLOTS];
  logic [31:0]      rem_mem [SLOTS];

  logic             cur_valid;
  logic [31:0]      cur_ev;
  logic [31:0]      cur_ctx;
  logic [31:0]      cur_rem;
  logic [32:0]      diff;
  logic [31:0]      rem_sat;
  logic             due_hit;
  logic             cancel_hit;
  logic [31:0]      sel_elapsed;
  logic [31:0]      tick_prod;
  logic             tstart;

  assign cur_valid = valid[idx];
  assign cur_ev    = ev_mem[idx];
  assign cur_ctx   = ctx_mem[idx];
  assign cur_rem   = rem_mem[idx];

  // floor at zero: a borrow means the slot is overdue
  assign diff       = {1'b0, cur_rem} - {1'b0, applied};
  assign rem_sat    = diff[32] ? 32'd0 : diff[31:0];
  assign due_hit    = cur_valid && (rem_sat == 32'd0);
  assign cancel_hit = cur_valid && (cur_ev == in_r.event_id) &&
                      ((in_r.event_context == 32'd0) || (cur_ctx == in_r.event_context));

  assign sel_elapsed = (in_r.callback_word[31:24] == ESC_BYTE) ?
                       (in_r.callback_word & ELAPSED_MASK) : armed_delay;
  assign tick_prod   = in_item.tick_now * MS_MULT;
  assign tstart      = (next_min != INT_MAX_MARK) && (next_min != 32'd0);

  always_comb begin
    sts.op           = in_r.op;
    sts.ev_zero      = (in_r.event_id == 32'd0);
    sts.delay_small  = (in_r.delay_ms < MIN_DELAY);
    sts.slot_valid   = cur_valid;
    sts.removed_zero = (removed == '0) && !cancel_hit;
    sts.due_hit      = due_hit;
    sts.idx_last     = (idx == IDX_W'(SLOTS - 1));
  end

  always_comb begin
    res = '0;
    if (cmd.emit_due) begin
      res.due_event   = cur_ev;
      res.due_context = cur_ctx;
    end else begin
      res.item_kind     = 1'b1;
      res.status        = sum_status;
      res.slot_used     = 5'(sum_slot);
      res.cleared_count = 5'(removed);
      res.last          = 1'b1;
      if (sum_step) begin
        res.elapsed_ms         = shown;
        res.soonest_delay      = next_min;
        res.timer_start        = tstart;
        res.empty_reload       = !active;
        res.int_max_suppressed = active && (next_min == INT_MAX_MARK);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      armed_delay <= '0;
      armed_start <= '0;
      p_live      <= 1'b0;
      active      <= 1'b0;
      idx         <= '0;
    end else begin
      if (cmd.find_take) begin
        valid[idx] <= 1'b1;
      end
      if (cmd.cancel_scan && cancel_hit) begin
        valid[idx] <= 1'b0;
      end
      if (cmd.step_scan && due_hit) begin
        valid[idx] <= 1'b0;
      end
      p_live <= cmd.step_scan && cur_valid && !due_hit;
      if (cmd.min_clr) begin
        active <= 1'b0;
      end else if (p_live) begin
        active <= 1'b1;
      end
      if (cmd.emit_sum && sum_step && tstart) begin
        armed_delay <= next_min;
        armed_start <= now_ms;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= IDX_W'(idx + 1'b1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r   <= in_item;
      now_ms <= tick_prod >> MS_SHIFT;
    end
    if (cmd.decode) begin
      elapsed  <= now_ms - armed_start;
      removed  <= '0;
      sum_slot <= '0;
      applied  <= sel_elapsed;
      shown    <= sel_elapsed;
    end
    if (cmd.use_elapsed) begin
      applied <= elapsed & ELAPSED_MASK;
      shown   <= elapsed;
    end
    if (cmd.sum_set) begin
      sum_status <= cmd.sum_code;
      sum_step   <= cmd.sum_step;
    end
    if (cmd.sum_full) begin
      sum_slot <= CNT_W'(SLOTS);
    end
    if (cmd.find_take) begin
      ev_mem[idx]  <= in_r.event_id;
      ctx_mem[idx] <= in_r.event_context;
      rem_mem[idx] <= in_r.delay_ms + elapsed;
      sum_slot     <= CNT_W'(idx);
    end
    if (cmd.cancel_scan && cancel_hit) begin
      removed <= CNT_W'(removed + 1'b1);
    end
    if (cmd.step_scan && cur_valid) begin
      rem_mem[idx] <= rem_sat;
    end
    p_rem <= rem_sat;
    if (cmd.min_clr) begin
      next_min <= '1;
    end else if (p_live && (p_rem < next_min)) begin
      next_min <= p_rem;
    end
  end

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.find_take |-> !cur_valid)
    else $error("schedule wrote over a live slot");

  a_empty_next: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sum && sum_step && !active) |-> (next_min == 32'hFFFF_FFFF))
    else $error("empty table summary without all-ones next delay");

endmodule

>>> rtl/core/dett_ctrl.sv
// ----------------------------------------------------------------------------
// dett_ctrl
// Sequencer: decode, free slot search, cancel scan, expiry scan, summary.
// ----------------------------------------------------------------------------
module dett_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_free,
  input  dett_pkg::sts_t  sts,
  output dett_pkg::cmd_t  cmd
);
  import dett_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_FIND    = 3'd2;
  localparam logic [2:0] S_CANCEL  = 3'd3;
  localparam logic [2:0] S_STEP    = 3'd4;
  localparam logic [2:0] S_FLUSH   = 3'd5;
  localparam logic [2:0] S_SUMMARY = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.op == OP_STEP) begin
          cmd.min_clr  = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.sum_set  = 1'b1;
          cmd.sum_step = 1'b1;
          cmd.sum_code = ST_DONE;
          state_next   = S_STEP;
        end else if ((sts.op == OP_BAD) || sts.ev_zero) begin
          cmd.sum_set  = 1'b1;
          cmd.sum_code = ST_BAD;
          state_next   = S_SUMMARY;
        end else if ((sts.op == OP_SCHED) && sts.delay_small) begin
          cmd.sum_set  = 1'b1;
          cmd.sum_code = ST_PUSH;
          state_next   = S_SUMMARY;
        end else if (sts.op == OP_SCHED) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_FIND;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_CANCEL;
        end
      end
      S_FIND: begin
        priority if (!sts.slot_valid) begin
          cmd.find_take   = 1'b1;
          cmd.use_elapsed = 1'b1;
          cmd.min_clr     = 1'b1;
          cmd.idx_clr     = 1'b1;
          cmd.sum_set     = 1'b1;
          cmd.sum_step    = 1'b1;
          cmd.sum_code    = ST_SCHED;
          state_next      = S_STEP;
        end else if (sts.idx_last) begin
          cmd.sum_set  = 1'b1;
          cmd.sum_code = ST_FULL;
          cmd.sum_full = 1'b1;
          state_next   = S_SUMMARY;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CANCEL: begin
        cmd.cancel_scan = 1'b1;
        priority if (sts.idx_last && sts.removed_zero) begin
          cmd.sum_set  = 1'b1;
          cmd.sum_code = ST_DONE;
          state_next   = S_SUMMARY;
        end else if (sts.idx_last) begin
          cmd.use_elapsed = 1'b1;
          cmd.min_clr     = 1'b1;
          cmd.idx_clr     = 1'b1;
          cmd.sum_set     = 1'b1;
          cmd.sum_step    = 1'b1;
          cmd.sum_code    = ST_DONE;
          state_next      = S_STEP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_STEP: begin
        // hold the slot while a due item cannot be handed over
        if (!(sts.due_hit && !out_free)) begin
          cmd.step_scan = 1'b1;
          cmd.emit_due  = sts.due_hit;
          if (sts.idx_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        state_next = S_SUMMARY;
      end
      S_SUMMARY: begin
        if (out_free) begin
          cmd.emit_sum = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_due_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && sts.due_hit && !out_free) |=> (state == S_STEP))
    else $error("scan left a stalled due slot");

endmodule

>>> rtl/core/delayed_event_timer_table.sv
// ----------------------------------------------------------------------------
// delayed_event_timer_table
// Table of delayed events sharing one millisecond timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_item carries one operation per item:
//   timer expiry step, schedule or cancel. Output channel
//   out_valid/out_ready/out_item returns zero or more due records (expired
//   events in slot order) followed by one summary record with last set.
//   One item is worked at a time; in_ready is high only while idle.
//   Path per item: a rejected operation passes accept, decode and summary;
//   an expiry step adds the subtract-and-minimum pass over all slots and a
//   flush before the summary; a schedule first searches for a free slot,
//   then runs that pass (a full table goes to the summary after the
//   search); a cancel runs a match scan, then that pass when something
//   matched. The controller walks the slot store through a single read
//   port, one entry per cycle while no due record waits on the output,
//   once for the search or cancel match and once for the
//   subtract-and-minimum pass.
//   Reset clears the live bits of all slots and the armed delay and start;
//   no clearing pass is needed. A stalled receiver holds the scan on the
//   slot whose due record is waiting; the output register frees one record
//   per accepted handshake.
// ----------------------------------------------------------------------------
module delayed_event_timer_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dett_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output dett_pkg::out_t out_item
);
  import dett_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_t res;
  logic out_free;

  // output register can take a new record when empty or being drained
  assign out_free = !out_valid || out_ready;

  dett_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  dett_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  // advance the output register on each emitted record, drop on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_due || cmd.emit_sum) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_due || cmd.emit_sum) begin
      out_item <= res;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_due || cmd.emit_sum) |-> out_free)
    else $error("record emitted into a full output register");

endmodule

>>> bench/tb_delayed_event_timer_table.sv
// ----------------------------------------------------------------------------
// tb_delayed_event_timer_table
// Self-checking bench for the delayed event timer table. A scoreboard class
// keeps its own copy of the slot table and the armed timer. For every accepted
// operation it predicts the due records and the summary, then checks each
// returned record in order. The stimulus opens with a directed sequence and
// then runs random operation mixes. Both handshakes see random idle gaps.
// ----------------------------------------------------------------------------
module tb_delayed_event_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dett_pkg::*;

  // Scoreboard: mirrors the slot table and holds the records still owed by
  // the block, oldest first.
  class timer_table_board;
    logic [31:0] ev_tab  [SLOTS];
    logic [31:0] ctx_tab [SLOTS];
    logic [31:0] rem_tab [SLOTS];
    logic [31:0] armed_delay;
    logic [31:0] armed_start;
    out_t        expected_records [$];
    int unsigned mismatches;
    int unsigned records_ok;
    int unsigned due_total;
    int unsigned full_hits;
    int unsigned suppressed_hits;
    int unsigned op_count [4];

    function new();
      foreach (ev_tab[i]) begin
        ev_tab[i]  = '0;
        ctx_tab[i] = '0;
        rem_tab[i] = '0;
      end
      foreach (op_count[i]) op_count[i] = 0;
      armed_delay     = '0;
      armed_start     = '0;
      mismatches      = 0;
      records_ok      = 0;
      due_total       = 0;
      full_hits       = 0;
      suppressed_hits = 0;
    endfunction

    function logic [31:0] ms_of_tick(logic [31:0] tick);
      logic [31:0] scaled;
      scaled = tick * MS_MULT;
      return scaled >> MS_SHIFT;
    endfunction

    function void owe_summary_only(logic [2:0] status, logic [4:0] slot);
      out_t r;
      r           = '0;
      r.item_kind = 1'b1;
      r.status    = status;
      r.slot_used = slot;
      r.last      = 1'b1;
      expected_records.push_back(r);
    endfunction

    // Age every live slot, owe a due record for each one that runs out, then
    // find the smallest remaining delay and re-arm the timer with it unless it is the int-max mark.
    function void expire_pass(logic [31:0] applied, logic [31:0] now_ms,
                              logic [2:0] status, logic [4:0] slot,
                              logic [4:0] removed, logic [31:0] shown);
      out_t        r;
      logic [31:0] nearest;
      logic        active;
      logic        arm;
      nearest = 32'hFFFF_FFFF;
      active  = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (ev_tab[i] != 0) begin
          rem_tab[i] = (rem_tab[i] > applied) ? rem_tab[i] - applied : '0;
          if (rem_tab[i] == 0) begin
            r             = '0;
            r.due_event   = ev_tab[i];
            r.due_context = ctx_tab[i];
            expected_records.push_back(r);
            ev_tab[i] = '0;
          end
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (ev_tab[i] != 0) begin
          active = 1'b1;
          if (rem_tab[i] < nearest) nearest = rem_tab[i];
        end
      end
      arm = (nearest != INT_MAX_MARK) && (nearest != 0);
      if (arm) begin
        armed_delay = nearest;
        armed_start = now_ms;
      end
      r                    = '0;
      r.item_kind          = 1'b1;
      r.status             = status;
      r.slot_used          = slot;
      r.cleared_count      = removed;
      r.elapsed_ms         = shown;
      r.soonest_delay      = nearest;
      r.timer_start        = arm;
      r.empty_reload       = !active;
      r.int_max_suppressed = active && (nearest == INT_MAX_MARK);
      r.last               = 1'b1;
      if (r.int_max_suppressed) suppressed_hits++;
      expected_records.push_back(r);
    endfunction

    // Note one accepted operation: update the table and owe its records.
    function void note_op(in_t it);
      logic [31:0] now_ms;
      logic [31:0] applied;
      logic [31:0] elapsed;
      int          free_idx;
      int          removed;
      now_ms   = ms_of_tick(it.tick_now);
      free_idx = -1;
      removed  = 0;
      op_count[it.op]++;
      if (it.op == OP_STEP) begin
        applied = (it.callback_word[31:24] == ESC_BYTE) ?
                  (it.callback_word & ELAPSED_MASK) : armed_delay;
        expire_pass(applied, now_ms, ST_DONE, '0, '0, applied);
      end else if (it.op == OP_BAD || it.event_id == 0) begin
        owe_summary_only(ST_BAD, '0);
      end else if (it.op == OP_SCHED) begin
        if (it.delay_ms < MIN_DELAY) begin
          owe_summary_only(ST_PUSH, '0);
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (ev_tab[i] == 0) free_idx = i;
          end
          if (free_idx < 0) begin
            full_hits++;
            owe_summary_only(ST_FULL, 5'(SLOTS));
          end else begin
            elapsed           = now_ms - armed_start;
            ev_tab[free_idx]  = it.event_id;
            ctx_tab[free_idx] = it.event_context;
            rem_tab[free_idx] = it.delay_ms + elapsed;
            expire_pass(elapsed & ELAPSED_MASK, now_ms, ST_SCHED, 5'(free_idx),
                        '0, elapsed);
          end
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ev_tab[i] == it.event_id &&
              (it.event_context == 0 || ctx_tab[i] == it.event_context)) begin
            ev_tab[i] = '0;
            removed++;
          end
        end
        if (removed == 0) begin
          owe_summary_only(ST_DONE, '0);
        end else begin
          elapsed = now_ms - armed_start;
          expire_pass(elapsed & ELAPSED_MASK, now_ms, ST_DONE, '0, 5'(removed),
                      elapsed);
        end
      end
    endfunction

    function string show(out_t r);
      return $sformatf({"kind=%0d ev=%h ctx=%h st=%0d slot=%0d rm=%0d el=%h ",
                        "next=%h start=%0d empty=%0d sup=%0d last=%0d"},
                       r.item_kind, r.due_event, r.due_context, r.status,
                       r.slot_used, r.cleared_count, r.elapsed_ms, r.soonest_delay,
                       r.timer_start, r.empty_reload, r.int_max_suppressed,
                       r.last);
    endfunction

    // Check one returned record against the oldest owed record.
    function void check_record(out_t got);
      out_t  want;
      string diffs;
      diffs = "";
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %s", show(got));
        return;
      end
      want = expected_records.pop_front();
      if (got.item_kind !== want.item_kind) diffs = {diffs, " item_kind"};
      if (got.due_event !== want.due_event) diffs = {diffs, " due_event"};
      if (got.due_context !== want.due_context) diffs = {diffs, " due_context"};
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.slot_used !== want.slot_used) diffs = {diffs, " slot_used"};
      if (got.cleared_count !== want.cleared_count) diffs = {diffs, " cleared_count"};
      if (got.elapsed_ms !== want.elapsed_ms) diffs = {diffs, " elapsed_ms"};
      if (got.soonest_delay !== want.soonest_delay) diffs = {diffs, " soonest_delay"};
      if (got.timer_start !== want.timer_start) diffs = {diffs, " timer_start"};
      if (got.empty_reload !== want.empty_reload) diffs = {diffs, " empty_reload"};
      if (got.int_max_suppressed !== want.int_max_suppressed)
        diffs = {diffs, " int_max_suppressed"};
      if (got.last !== want.last) diffs = {diffs, " last"};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("record mismatch at %0t on%s", $realtime, diffs);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end else begin
        records_ok++;
        if (want.item_kind == 1'b0) due_total++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_item;
  logic out_valid;
  logic out_ready;
  out_t out_item;

  timer_table_board board;
  bit               rush_in;   // sender skips its idle gaps while set
  bit               rush_out;  // receiver skips its stalls while set
  logic [31:0]      tick_run;  // free-running kernel tick for random items

  delayed_event_timer_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #1ms;
    $display("delayed_event_timer_table regression: fail");
    $finish;
  end

  // Sample both handshakes on the edge that completes them. One block keeps
  // the noting of inputs and the checking of results in a fixed order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_op(in_item);
      if (out_valid && out_ready) board.check_record(out_item);
    end
  end

  // Result sink: draw a stall before each record, then hold ready until the
  // record is taken. Stretches without stalls come and go at random.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken     = 0;
    rush_out  = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 24 == 0) rush_out = ($urandom_range(0, 2) == 0);
      stall = rush_out ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  function automatic in_t mk_op(logic [1:0] op, logic [31:0] ev, logic [31:0] ctx,
                                logic [31:0] delay, logic [31:0] tick,
                                logic [31:0] cbw);
    in_t it;
    it.op            = op;
    it.event_id      = ev;
    it.event_context = ctx;
    it.delay_ms      = delay;
    it.tick_now      = tick;
    it.callback_word = cbw;
    return it;
  endfunction

  // Build one random operation. While filling, schedules with long delays
  // dominate so the table runs full; otherwise steps and cancels keep it
  // churning. A share of items is pure noise with every field random.
  function automatic in_t random_op(bit filling);
    in_t         it;
    int unsigned pick;
    int unsigned k;
    tick_run += $urandom_range(0, 2500);
    it = mk_op(OP_STEP, $urandom_range(1, 6), $urandom_range(1, 4),
               $urandom_range(2, 3000), tick_run,
               {ESC_BYTE, 24'($urandom_range(0, 2500))});
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 70 : 35)) begin
      it.op = OP_SCHED;
      if (filling) it.delay_ms = $urandom_range(2000, 40000);
      case ($urandom_range(0, 9))
        0: it.delay_ms = $urandom;
        1: it.delay_ms = MIN_DELAY;
        2: it.delay_ms = INT_MAX_MARK;
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) it.event_context = $urandom;
    end else if (pick < (filling ? 80 : 65)) begin
      // step: mostly an explicit elapsed time, sometimes the armed delay
      case ($urandom_range(0, 5))
        0: it.callback_word = $urandom;
        1: it.callback_word = {ESC_BYTE, 24'($urandom)};
        default: ;
      endcase
    end else if (pick < (filling ? 90 : 85)) begin
      // cancel: aim at a live slot when one is there
      it.op = OP_CANCEL;
      k = $urandom_range(0, SLOTS - 1);
      if (board.ev_tab[k] != 0) begin
        it.event_id      = board.ev_tab[k];
        it.event_context = $urandom_range(0, 1) ? 32'd0 : board.ctx_tab[k];
      end else if ($urandom_range(0, 1)) begin
        it.event_context = '0;
      end
    end else begin
      it = mk_op(2'($urandom_range(0, 3)), $urandom_range(0, 1) ? 32'd0 : $urandom,
                 $urandom, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) : $urandom,
                 $urandom, $urandom);
    end
    return it;
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_op(input in_t it);
    int unsigned gap;
    gap = rush_in ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every owed record has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_records.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] fill_ev;
    logic [31:0] fill_ctx;
    logic [31:0] fill_delay;
    logic [31:0] fill_tick;
    bit          filling;
    board    = new();
    rush_in  = 1'b0;
    filling  = 1'b0;
    tick_run = 32'd4096;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening. Expire on an empty table with nothing armed: the
    // all-ones next delay still arms the timer.
    send_op(mk_op(OP_STEP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    // Rejections: zero event on schedule and cancel, the unused op code,
    // delays too short to schedule, and a cancel that matches nothing.
    send_op(mk_op(OP_SCHED, 32'd0, 32'hFFFF_FFFF, 32'd500, 32'd0, 32'd0));
    send_op(mk_op(OP_CANCEL, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_op(mk_op(OP_BAD, 32'd5, 32'd1, 32'd500, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(mk_op(OP_SCHED, 32'd5, 32'd1, 32'd0, 32'd0, 32'd0));
    send_op(mk_op(OP_SCHED, 32'd5, 32'd1, 32'd1, 32'd0, 32'd0));
    send_op(mk_op(OP_CANCEL, 32'd7, 32'd0, 32'd0, 32'd0, 32'd0));

    // Fill every slot. The first slot holds the int-max mark alone so the
    // suppressed flag shows; then an all-ones delay, the minimum delay, and
    // a spread of delays with repeated event codes for the cancels below.
    for (int i = 0; i < SLOTS; i++) begin
      fill_ev    = (i % 4 == 0) ? 32'd9 : (i == 5) ? 32'hFFFF_FFFF : 32'(100 + i);
      fill_ctx   = (i == 3) ? 32'hFFFF_FFFF : 32'(i % 3);
      fill_tick  = (i < 2) ? 32'd0 : 32'd1024;
      fill_delay = (i == 0) ? INT_MAX_MARK : (i == 1) ? 32'hFFFF_FFFF :
                   (i == 2) ? MIN_DELAY : 32'(i * 250);
      send_op(mk_op(OP_SCHED, fill_ev, fill_ctx, fill_delay, fill_tick, 32'd0));
    end
    send_op(mk_op(OP_SCHED, 32'd77, 32'd1, 32'd10, 32'd1024, 32'd0));
    // Cancel one context exactly, then the rest of the event with the
    // wildcard context; time has moved so the short slot falls due too.
    send_op(mk_op(OP_CANCEL, 32'd9, 32'd2, 32'd0, 32'd2048, 32'd0));
    send_op(mk_op(OP_CANCEL, 32'd9, 32'd0, 32'd0, 32'd2048, 32'd0));
    // Largest explicit elapsed time: most slots fall due in one step.
    send_op(mk_op(OP_STEP, 32'd0, 32'd0, 32'd0, 32'd3072,
                  {ESC_BYTE, 24'hFF_FFFF}));
    drain_results();

    // Random mixes in segments of twenty items.
    for (int n = 0; n < 145; n++) begin
      if (n % 20 == 0) begin
        filling = ($urandom_range(0, 2) == 0);
        rush_in = ($urandom_range(0, 3) == 0);
      end
      if (n == 85) drain_results();
      send_op(random_op(filling));
    end

    drain_results();
    repeat (60) @(posedge clk);

    $display("covered %0d ops (step %0d, schedule %0d, cancel %0d, unused code %0d)",
             board.op_count[0] + board.op_count[1] + board.op_count[2] +
             board.op_count[3], board.op_count[0], board.op_count[1],
             board.op_count[2], board.op_count[3]);
    $display("%0d records matched, %0d due events, %0d table-full, %0d int-max held",
             board.records_ok, board.due_total, board.full_hits,
             board.suppressed_hits);
    if (board.mismatches == 0 && board.expected_records.size() == 0) begin
      $display("delayed_event_timer_table regression: pass");
    end else begin
      $display("delayed_event_timer_table regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dett_pkg.sv
rtl/core/dett_dp.sv
rtl/core/dett_ctrl.sv
rtl/core/delayed_event_timer_table.sv
bench/tb_delayed_event_timer_table.sv
